// ===== src/bstk_pkg.sv =====
package bstk_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RW    = 7;
  localparam int UW    = (CW > RW) ? CW : RW;
  localparam int VW    = 32;

  localparam logic [RW-1:0] CAP_RESET = RW'(64);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FIND  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  // report a count or a position in the 7-bit result fields
  function automatic logic [RW-1:0] to_rw(input logic [CW-1:0] v);
    logic [CW+RW-1:0] ext;
    ext = {{RW{1'b0}}, v};
    return ext[RW-1:0];
  endfunction

endpackage

// ===== src/bounded_stack_with_search_top.sv =====
// Bounded LIFO stack of signed 32-bit words held in one single-port-read
// synchronous memory. Push and clear are answered from the idle state and
// their word waits in the output register; pop runs through memory read,
// capture and output; find reads one stored entry per cycle from the bottom
// up and stops at the first match. Pop and find on an empty stack need no
// read. One item is worked on at a time. The cfg port writes the capacity
// register as given; a push is also refused at the memory depth. Lowering
// it below the current count keeps the entries. No clearing pass runs
// after reset: entries are only read after a push wrote them.
module bounded_stack_with_search_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,   // value[31:0]
  input  logic [1:0]               s_tuser,   // opcode[1:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [47:0]              m_tdata,   // data[31:0], position[38:32], count[45:39]
  output logic [1:0]               m_tuser,   // status[1:0]
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bstk_pkg::RW-1:0]  cfg_data
);

  import bstk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_FIND = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [RW-1:0]   cap;
  logic [VW-1:0]   key;
  logic [CW-1:0]   idx;
  logic            rd_pend;
  logic [AW-1:0]   rd_idx;
  status_t         res_status;
  logic [VW-1:0]   res_data;
  logic [RW-1:0]   res_pos;

  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [VW-1:0]   ram_rdata;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            full;
  logic            hit;
  logic            scan_done;
  opcode_t         op;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign op        = opcode_t'(s_tuser);

  // load the output register from an immediate answer or a finished pop or find
  assign out_load  = (accept && (op == OP_PUSH || op == OP_CLEAR || count == '0)) ||
                     (state == S_RESP && out_free);

  assign full      = (UW'(count) >= UW'(cap)) || (count == CW'(DEPTH));
  assign hit       = rd_pend && (ram_rdata == key);
  assign scan_done = !hit && (idx == count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept && op == OP_PUSH && !full) begin
          ram_we = 1'b1;
        end
        if (accept && op == OP_POP && count != '0) begin
          ram_re    = 1'b1;
          ram_raddr = count[AW-1:0] - AW'(1);
        end
      end
      S_FIND: begin
        if (!hit && idx != count) begin
          ram_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  bstk_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cap      <= CAP_RESET;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_PUSH: begin
                if (full) begin
                  m_tuser <= ST_FULL;
                  m_tdata <= {2'b00, to_rw(count), {RW{1'b0}}, {VW{1'b0}}};
                end else begin
                  count   <= count + CW'(1);
                  m_tuser <= ST_OK;
                  m_tdata <= {2'b00, to_rw(count + CW'(1)), {RW{1'b0}}, {VW{1'b0}}};
                end
              end
              OP_POP: begin
                if (count == '0) begin
                  m_tuser  <= ST_EMPTY;
                  m_tdata  <= '0;
                end else begin
                  count <= count - CW'(1);
                  state <= S_POP;
                end
              end
              OP_FIND: begin
                if (count == '0) begin
                  m_tuser  <= ST_NOMATCH;
                  m_tdata  <= '0;
                end else begin
                  key     <= s_tdata;
                  idx     <= '0;
                  rd_pend <= 1'b0;
                  state   <= S_FIND;
                end
              end
              OP_CLEAR: begin
                count    <= '0;
                m_tuser  <= ST_OK;
                m_tdata  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          res_status <= ST_OK;
          res_data   <= ram_rdata;
          res_pos    <= '0;
          state      <= S_RESP;
        end
        S_FIND: begin
          // compare the word read last cycle while the next read goes out
          if (hit) begin
            res_status <= ST_OK;
            res_data   <= key;
            res_pos    <= to_rw(CW'(rd_idx) + CW'(1));
            rd_pend    <= 1'b0;
            state      <= S_RESP;
          end else if (scan_done) begin
            res_status <= ST_NOMATCH;
            res_data   <= '0;
            res_pos    <= '0;
            rd_pend    <= 1'b0;
            state      <= S_RESP;
          end else begin
            rd_pend <= 1'b1;
            rd_idx  <= idx[AW-1:0];
            idx     <= idx + CW'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, to_rw(count), res_pos, res_data};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    UW'(count) <= UW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_PUSH && !full) |=> count == $past(count) + CW'(1))
    else $error("accepted push did not grow the stack");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> (idx <= count && count != '0))
    else $error("search index past the top entry");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE && !ram_re))
    else $error("memory write outside an accepted push");

  a_pend_find: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_FIND)
    else $error("pending search read outside the search");
`endif

endmodule

// ===== src/bstk_ram.sv =====
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last word read until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
